// ===== rtl/blsu_pkg.sv =====
package blsu_pkg;

   localparam int unsigned VALUE_W  = 32;
   localparam int unsigned POS_W    = 8;
   localparam int unsigned KIND_W   = 3;
   localparam int unsigned STATUS_W = 2;

   localparam logic [KIND_W-1:0] REQ_READ      = 3'd0;
   localparam logic [KIND_W-1:0] REQ_INS_FRONT = 3'd1;
   localparam logic [KIND_W-1:0] REQ_INS_BACK  = 3'd2;
   localparam logic [KIND_W-1:0] REQ_REMOVE    = 3'd3;
   localparam logic [KIND_W-1:0] REQ_DUMP      = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   localparam logic signed [VALUE_W-1:0] MISS_VALUE = -32'sd1;

   typedef struct packed {
      logic [KIND_W-1:0]         req_type;
      logic [POS_W-1:0]          position;
      logic signed [VALUE_W-1:0] item_value;
   } req_beat_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] read_value;
      logic [STATUS_W-1:0]       status;
      logic                      last;
   } rsp_beat_type;

   typedef enum logic [1:0] {
      RD_REQ  = 2'd0,
      RD_IDX  = 2'd1,
      RD_NEXT = 2'd2
   } rd_sel_type;

   typedef enum logic [1:0] {
      WR_NONE  = 2'd0,
      WR_FRONT = 2'd1,
      WR_BACK  = 2'd2,
      WR_SHIFT = 2'd3
   } wr_kind_type;

   typedef enum logic [2:0] {
      RSP_DATA  = 3'd0,
      RSP_MISS  = 3'd1,
      RSP_OK    = 3'd2,
      RSP_RANGE = 3'd3,
      RSP_FULL  = 3'd4
   } rsp_kind_type;

   typedef struct packed {
      logic         accept;
      logic         idx_zero;
      logic         idx_inc;
      logic         count_dec;
      rd_sel_type   rd_sel;
      wr_kind_type  wr_kind;
      logic         rsp_load;
      rsp_kind_type rsp_kind;
      logic         rsp_last;
   } cmd_type;

   typedef struct packed {
      logic in_range;
      logic full;
      logic empty;
      logic walk_end;
      logic is_front;
      logic out_free;
   } stat_type;

endpackage

// ===== rtl/bounded_indexed_list_store_unit.sv =====
// Ordered list of up to CAPACITY signed 32-bit values held in a ring in one
// single-port-read RAM, tracked by a head slot and an entry count. Requests
// run one at a time. An in-range remove at position p walks from p to the end
// of the list, and a dump walks every entry; each step of these walks waits
// on the registered RAM read. A result beat waiting in the output register
// does not block the next request from being accepted. Storage needs no
// clearing after reset.
module bounded_indexed_list_store_unit #(
   parameter int unsigned CAPACITY = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  blsu_pkg::req_beat_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output blsu_pkg::rsp_beat_type rsp_data
);

   blsu_pkg::cmd_type  cmd;
   blsu_pkg::stat_type stat;

   blsu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_data.req_type),
      .stat      (stat),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   blsu_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule

// ===== rtl/blsu_ram.sv =====
module blsu_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/blsu_ctrl.sv =====
module blsu_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic [blsu_pkg::KIND_W-1:0]   req_kind,
   input  blsu_pkg::stat_type            stat,
   output logic                          req_stall,
   output blsu_pkg::cmd_type             cmd
);

   typedef enum logic [6:0] {
      S_IDLE     = 7'b0000001,
      S_READ     = 7'b0000010,
      S_INSERT   = 7'b0000100,
      S_REMOVE   = 7'b0001000,
      S_SHIFT    = 7'b0010000,
      S_DUMP     = 7'b0100000,
      S_DUMP_OUT = 7'b1000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      cmd           = '0;
      cmd.rd_sel    = blsu_pkg::RD_IDX;
      cmd.wr_kind   = blsu_pkg::WR_NONE;
      cmd.rsp_kind  = blsu_pkg::RSP_OK;
      cmd.rsp_last  = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall  = 1'b0;
            cmd.rd_sel = blsu_pkg::RD_REQ;
            if (req_valid) begin
               cmd.accept   = 1'b1;
               cmd.idx_zero = (req_kind == blsu_pkg::REQ_DUMP);
               case (req_kind)
                  blsu_pkg::REQ_READ:      state_in = S_READ;
                  blsu_pkg::REQ_INS_FRONT: state_in = S_INSERT;
                  blsu_pkg::REQ_INS_BACK:  state_in = S_INSERT;
                  blsu_pkg::REQ_REMOVE:    state_in = S_REMOVE;
                  blsu_pkg::REQ_DUMP:      state_in = S_DUMP;
                  default:                 state_in = S_IDLE;
               endcase
            end
         end
         S_READ: begin
            if (stat.out_free) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_kind = stat.in_range ? blsu_pkg::RSP_DATA : blsu_pkg::RSP_MISS;
               state_in     = S_IDLE;
            end
         end
         S_INSERT: begin
            if (stat.out_free) begin
               cmd.rsp_load = 1'b1;
               if (stat.full) begin
                  cmd.rsp_kind = blsu_pkg::RSP_FULL;
               end else begin
                  cmd.rsp_kind = blsu_pkg::RSP_OK;
                  cmd.wr_kind  = stat.is_front ? blsu_pkg::WR_FRONT : blsu_pkg::WR_BACK;
               end
               state_in = S_IDLE;
            end
         end
         S_REMOVE: begin
            cmd.rd_sel = blsu_pkg::RD_NEXT;
            if (!stat.in_range) begin
               if (stat.out_free) begin
                  cmd.rsp_load = 1'b1;
                  cmd.rsp_kind = blsu_pkg::RSP_RANGE;
                  state_in     = S_IDLE;
               end
            end else if (stat.walk_end) begin
               if (stat.out_free) begin
                  cmd.rsp_load  = 1'b1;
                  cmd.rsp_kind  = blsu_pkg::RSP_OK;
                  cmd.count_dec = 1'b1;
                  state_in      = S_IDLE;
               end
            end else begin
               state_in = S_SHIFT;
            end
         end
         S_SHIFT: begin
            cmd.wr_kind = blsu_pkg::WR_SHIFT;
            cmd.idx_inc = 1'b1;
            state_in    = S_REMOVE;
         end
         S_DUMP: begin
            state_in = stat.empty ? S_IDLE : S_DUMP_OUT;
         end
         S_DUMP_OUT: begin
            if (stat.out_free) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_kind = blsu_pkg::RSP_DATA;
               cmd.rsp_last = stat.walk_end;
               cmd.idx_inc  = 1'b1;
               state_in     = stat.walk_end ? S_IDLE : S_DUMP;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/blsu_dp.sv =====
module blsu_dp #(
   parameter int unsigned CAPACITY = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  blsu_pkg::req_beat_type req_data,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output blsu_pkg::rsp_beat_type rsp_data,
   input  blsu_pkg::cmd_type      cmd,
   output blsu_pkg::stat_type     stat
);

   localparam int unsigned SW   = $clog2(CAPACITY);
   localparam int unsigned CW   = $clog2(CAPACITY + 1);
   localparam int unsigned CMPW = (CW > blsu_pkg::POS_W) ? CW : blsu_pkg::POS_W;

   blsu_pkg::req_beat_type req_ff;
   logic [SW-1:0]          head_ff, head_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [CW-1:0]          idx_ff, idx_in;
   logic [CW-1:0]          idx_next;
   logic                   rsp_valid_ff;
   blsu_pkg::rsp_beat_type rsp_ff, rsp_in;
   logic [SW-1:0]          head_dec;
   logic [SW-1:0]          rd_addr, wr_addr;
   logic                   wr_en;
   logic [blsu_pkg::VALUE_W-1:0] wr_data, rd_data;

   function automatic logic [SW-1:0] slot_of(input logic [SW-1:0] head,
                                             input logic [SW-1:0] off);
      logic [SW:0] sum;
      begin
         sum = {1'b0, head} + {1'b0, off};
         if (sum >= (SW+1)'(CAPACITY)) begin
            sum = sum - (SW+1)'(CAPACITY);
         end
         slot_of = sum[SW-1:0];
      end
   endfunction

   assign idx_next = idx_ff + CW'(1);
   assign head_dec = (head_ff == '0) ? SW'(CAPACITY - 1) : head_ff - SW'(1);

   always_comb begin
      case (cmd.rd_sel)
         blsu_pkg::RD_REQ:  rd_addr = slot_of(head_ff, req_data.position[SW-1:0]);
         blsu_pkg::RD_NEXT: rd_addr = slot_of(head_ff, idx_next[SW-1:0]);
         default:           rd_addr = slot_of(head_ff, idx_ff[SW-1:0]);
      endcase
   end

   always_comb begin
      wr_en   = 1'b1;
      wr_data = req_ff.item_value;
      case (cmd.wr_kind)
         blsu_pkg::WR_FRONT: wr_addr = head_dec;
         blsu_pkg::WR_BACK:  wr_addr = slot_of(head_ff, count_ff[SW-1:0]);
         blsu_pkg::WR_SHIFT: begin
            wr_addr = slot_of(head_ff, idx_ff[SW-1:0]);
            wr_data = rd_data;
         end
         default: begin
            wr_en   = 1'b0;
            wr_addr = head_ff;
         end
      endcase
   end

   blsu_ram #(
      .WIDTH (blsu_pkg::VALUE_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (cmd.wr_kind == blsu_pkg::WR_FRONT) begin
         head_in  = head_dec;
         count_in = count_ff + CW'(1);
      end else if (cmd.wr_kind == blsu_pkg::WR_BACK) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.count_dec) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.accept) begin
         idx_in = cmd.idx_zero ? '0 : req_data.position[CW-1:0];
      end else if (cmd.idx_inc) begin
         idx_in = idx_next;
      end
   end

   always_comb begin
      rsp_in.last = cmd.rsp_last;
      case (cmd.rsp_kind)
         blsu_pkg::RSP_DATA: begin
            rsp_in.read_value = signed'(rd_data);
            rsp_in.status     = blsu_pkg::ST_OK;
         end
         blsu_pkg::RSP_MISS: begin
            rsp_in.read_value = blsu_pkg::MISS_VALUE;
            rsp_in.status     = blsu_pkg::ST_RANGE;
         end
         blsu_pkg::RSP_RANGE: begin
            rsp_in.read_value = '0;
            rsp_in.status     = blsu_pkg::ST_RANGE;
         end
         blsu_pkg::RSP_FULL: begin
            rsp_in.read_value = '0;
            rsp_in.status     = blsu_pkg::ST_FULL;
         end
         default: begin
            rsp_in.read_value = '0;
            rsp_in.status     = blsu_pkg::ST_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= cmd.rsp_load | (rsp_valid_ff & rsp_stall);
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.accept) begin
         req_ff <= req_data;
      end
      if (cmd.rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign stat.in_range = CMPW'(req_ff.position) < CMPW'(count_ff);
   assign stat.full     = (count_ff == CW'(CAPACITY));
   assign stat.empty    = (count_ff == '0);
   assign stat.walk_end = (idx_next == count_ff);
   assign stat.is_front = (req_ff.req_type == blsu_pkg::REQ_INS_FRONT);
   assign stat.out_free = ~rsp_valid_ff | ~rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;

   localparam int CAP = 32;
   localparam int ITEMS_PER_PHASE = 62;
   localparam int NUM_PHASES = 4;
   localparam int HOLD_CYCLES = 250;
   localparam int SETTLE_CYCLES = 100;
   localparam int MAX_REPORTS = 10;

   typedef struct {
      blsu_pkg::req_beat_type beat;
      bit                     typed;
      blsu_pkg::rsp_beat_type want;
   } stim_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   blsu_pkg::req_beat_type req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   blsu_pkg::rsp_beat_type rsp_data;

   logic signed [blsu_pkg::VALUE_W-1:0] ring_mem [CAP];
   int                                  ring_head = 0;
   int                                  ring_count = 0;

   blsu_pkg::rsp_beat_type pending_rsp [$];
   stim_row_type           directed_rows [$];

   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   int  hold_left = 0;
   bit  hold_start = 1'b0;
   bit  hold_taken = 1'b0;
   int  error_count = 0;
   bit  growing = 1'b1;

   bounded_indexed_list_store_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #(12 * 500000);
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic void queue_rsp(input blsu_pkg::rsp_beat_type r);
      pending_rsp = {pending_rsp, r};
   endfunction

   function automatic void list_apply(input blsu_pkg::req_beat_type b);
      blsu_pkg::rsp_beat_type r;
      int                     i;
      r.read_value = '0;
      r.status     = blsu_pkg::ST_OK;
      r.last       = 1'b1;
      case (b.req_type)
         blsu_pkg::REQ_READ: begin
            if (int'(b.position) >= ring_count) begin
               r.read_value = blsu_pkg::MISS_VALUE;
               r.status     = blsu_pkg::ST_RANGE;
            end else begin
               r.read_value = ring_mem[(ring_head + int'(b.position)) % CAP];
            end
         end
         blsu_pkg::REQ_INS_FRONT: begin
            if (ring_count >= CAP) begin
               r.status = blsu_pkg::ST_FULL;
            end else begin
               ring_head = (ring_head + CAP - 1) % CAP;
               ring_mem[ring_head] = b.item_value;
               ring_count++;
            end
         end
         blsu_pkg::REQ_INS_BACK: begin
            if (ring_count >= CAP) begin
               r.status = blsu_pkg::ST_FULL;
            end else begin
               ring_mem[(ring_head + ring_count) % CAP] = b.item_value;
               ring_count++;
            end
         end
         blsu_pkg::REQ_REMOVE: begin
            if (int'(b.position) >= ring_count) begin
               r.status = blsu_pkg::ST_RANGE;
            end else begin
               for (i = int'(b.position); i + 1 < ring_count; i++) begin
                  ring_mem[(ring_head + i) % CAP] = ring_mem[(ring_head + i + 1) % CAP];
               end
               ring_count--;
            end
         end
         blsu_pkg::REQ_DUMP: begin
            for (i = 0; i < ring_count; i++) begin
               r.read_value = ring_mem[(ring_head + i) % CAP];
               r.last       = (i + 1 == ring_count);
               queue_rsp(r);
            end
            return;
         end
         default: return;
      endcase
      queue_rsp(r);
   endfunction

   function automatic blsu_pkg::req_beat_type pick_beat();
      blsu_pkg::req_beat_type b;
      int                     roll;
      roll = $urandom_range(99);
      b.item_value = $urandom;
      if (ring_count == 0 || $urandom_range(3) == 0) begin
         b.position = blsu_pkg::POS_W'($urandom_range(255));
      end else begin
         b.position = blsu_pkg::POS_W'($urandom_range(ring_count - 1));
      end
      if (roll < 4) begin
         b.req_type = blsu_pkg::REQ_DUMP + blsu_pkg::KIND_W'($urandom_range(3, 1));
      end else if (roll < 19) begin
         b.req_type = blsu_pkg::REQ_READ;
      end else if (roll < 29) begin
         b.req_type = blsu_pkg::REQ_DUMP;
      end else if (growing) begin
         b.req_type = (roll < 54) ? blsu_pkg::REQ_INS_FRONT :
                      (roll < 86) ? blsu_pkg::REQ_INS_BACK : blsu_pkg::REQ_REMOVE;
      end else begin
         b.req_type = (roll < 40) ? blsu_pkg::REQ_INS_FRONT :
                      (roll < 51) ? blsu_pkg::REQ_INS_BACK : blsu_pkg::REQ_REMOVE;
      end
      return b;
   endfunction

   task automatic send_beat(input blsu_pkg::req_beat_type b, input bit typed,
                            input blsu_pkg::rsp_beat_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      list_apply(b);
      if (typed && pending_rsp.size() > 0) pending_rsp[pending_rsp.size() - 1] = want;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_rsp.size() != 0) @(negedge clock);
   endtask

   task automatic add_row(input logic [blsu_pkg::KIND_W-1:0] kind,
                          input logic [blsu_pkg::POS_W-1:0] pos,
                          input logic signed [blsu_pkg::VALUE_W-1:0] value, input bit typed,
                          input logic signed [blsu_pkg::VALUE_W-1:0] want_value,
                          input logic [blsu_pkg::STATUS_W-1:0] want_status);
      stim_row_type row;
      row.beat.req_type   = kind;
      row.beat.position   = pos;
      row.beat.item_value = value;
      row.typed           = typed;
      row.want.read_value = want_value;
      row.want.status     = want_status;
      row.want.last       = 1'b1;
      directed_rows = {directed_rows, row};
   endtask

   function automatic void report_mismatch(input string what,
                                           input blsu_pkg::rsp_beat_type want,
                                           input blsu_pkg::rsp_beat_type got);
      error_count++;
      if (error_count <= MAX_REPORTS) begin
         $display("mismatch %s: expected value %0d status %0d last %0b,",
                  what, want.read_value, want.status, want.last);
         $display("   got value %0d status %0d last %0b",
                  got.read_value, got.status, got.last);
      end
   endfunction

   always @(negedge clock) begin
      if (hold_start && !hold_taken) begin
         hold_taken = 1'b1;
         hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      blsu_pkg::rsp_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            want = '0;
            report_mismatch("unexpected beat", want, rsp_data);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.read_value !== want.read_value) begin
               report_mismatch("read_value", want, rsp_data);
            end else if (rsp_data.status !== want.status) begin
               report_mismatch("status", want, rsp_data);
            end else if (rsp_data.last !== want.last) begin
               report_mismatch("last", want, rsp_data);
            end
         end
      end
   end

   initial begin
      int                     phase;
      int                     sent;
      blsu_pkg::req_beat_type b;
      blsu_pkg::rsp_beat_type none;
      none = '0;

      add_row(blsu_pkg::REQ_READ, 8'd0, 32'sd0, 1'b1,
              blsu_pkg::MISS_VALUE, blsu_pkg::ST_RANGE);
      add_row(blsu_pkg::REQ_REMOVE, 8'd0, 32'sd0, 1'b1, 32'sd0, blsu_pkg::ST_RANGE);
      add_row(blsu_pkg::REQ_DUMP, 8'd0, 32'sd0, 1'b0, 32'sd0, blsu_pkg::ST_OK);
      add_row(blsu_pkg::REQ_DUMP + 3'd1, 8'd0, 32'sd5, 1'b0, 32'sd0, blsu_pkg::ST_OK);
      add_row(blsu_pkg::REQ_DUMP + 3'd2, 8'hff, -32'sd1, 1'b0, 32'sd0, blsu_pkg::ST_OK);
      add_row(blsu_pkg::REQ_DUMP + 3'd3, 8'h80, 32'sh12345678, 1'b0, 32'sd0,
              blsu_pkg::ST_OK);
      add_row(blsu_pkg::REQ_INS_BACK, 8'hff, 32'sh7fffffff, 1'b1, 32'sd0, blsu_pkg::ST_OK);
      add_row(blsu_pkg::REQ_INS_FRONT, 8'hff, 32'sh80000000, 1'b1, 32'sd0, blsu_pkg::ST_OK);
      add_row(blsu_pkg::REQ_INS_BACK, 8'd0, 32'sd0, 1'b1, 32'sd0, blsu_pkg::ST_OK);
      add_row(blsu_pkg::REQ_INS_FRONT, 8'h55, -32'sd1, 1'b1, 32'sd0, blsu_pkg::ST_OK);
      add_row(blsu_pkg::REQ_READ, 8'd0, 32'sd0, 1'b0, 32'sd0, blsu_pkg::ST_OK);
      add_row(blsu_pkg::REQ_READ, 8'd3, -32'sd1, 1'b0, 32'sd0, blsu_pkg::ST_OK);
      add_row(blsu_pkg::REQ_READ, 8'd4, 32'sd0, 1'b1,
              blsu_pkg::MISS_VALUE, blsu_pkg::ST_RANGE);
      add_row(blsu_pkg::REQ_READ, 8'hff, 32'sd0, 1'b1,
              blsu_pkg::MISS_VALUE, blsu_pkg::ST_RANGE);
      add_row(blsu_pkg::REQ_DUMP, 8'hff, -32'sd1, 1'b0, 32'sd0, blsu_pkg::ST_OK);
      add_row(blsu_pkg::REQ_REMOVE, 8'hff, 32'sd0, 1'b1, 32'sd0, blsu_pkg::ST_RANGE);
      add_row(blsu_pkg::REQ_REMOVE, 8'd1, 32'sd0, 1'b1, 32'sd0, blsu_pkg::ST_OK);
      add_row(blsu_pkg::REQ_REMOVE, 8'd2, 32'sd0, 1'b1, 32'sd0, blsu_pkg::ST_OK);
      add_row(blsu_pkg::REQ_REMOVE, 8'd0, 32'sd0, 1'b1, 32'sd0, blsu_pkg::ST_OK);
      add_row(blsu_pkg::REQ_DUMP, 8'd0, 32'sd0, 1'b0, 32'sd0, blsu_pkg::ST_OK);
      add_row(blsu_pkg::REQ_REMOVE, 8'd0, 32'sd0, 1'b1, 32'sd0, blsu_pkg::ST_OK);
      add_row(blsu_pkg::REQ_DUMP, 8'd0, 32'sd0, 1'b0, 32'sd0, blsu_pkg::ST_OK);
      add_row(blsu_pkg::REQ_READ, 8'd0, 32'sd0, 1'b1,
              blsu_pkg::MISS_VALUE, blsu_pkg::ST_RANGE);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);
      end
      wait_drained();

      for (phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
               hold_start     = 1'b1;
            end
            1: begin
               send_idle_pct  = 59;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 59;
            end
            default: begin
               send_idle_pct  = 20;
               recv_stall_pct = 20;
            end
         endcase
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            if (ring_count == 0) growing = 1'b1;
            else if (ring_count >= CAP && $urandom_range(3) == 0) growing = 1'b0;
            b = pick_beat();
            send_beat(b, 1'b0, none);
            sent++;
         end
         wait_drained();
      end

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);

      if (error_count == 0 && pending_rsp.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== bounded_indexed_list_store_unit.f =====
rtl/blsu_pkg.sv
rtl/blsu_ram.sv
rtl/blsu_ctrl.sv
rtl/blsu_dp.sv
rtl/bounded_indexed_list_store_unit.sv
dv/tb.sv
